[sv/mprq_pkg.sv]
// ----------------------------------------------------------------------------
// mprq_pkg: shared types and codes of the min-priority ready queue
// Holds the command and result transfer types, the stored entry layout,
// the operation and status codes, the sequencer states, and the input
// bundle of the shared compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mprq_pkg;

  localparam int unsigned ENTRY_W = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PURGE   = 2'd2
  } mprq_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } mprq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } mprq_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] process_id;
    logic [7:0] priority_req;
  } mprq_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic [4:0] count_after;
    logic       is_empty;
  } mprq_result_t;

  // Stored entry: id in the high byte, priority in the low byte.
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } mprq_entry_t;

  typedef struct packed {
    logic        min_mode;
    logic        first;
    mprq_entry_t cand;
    mprq_entry_t best;
    logic [7:0]  key;
  } mprq_cmp_in_t;

endpackage

`default_nettype wire

[sv/min_priority_ready_queue.sv]
// ----------------------------------------------------------------------------
// min_priority_ready_queue: bounded ready queue served by lowest priority
// Entries are kept in arrival order in a RAM; a sequencer walks them with
// one shared compare unit and closes gaps by moving entries down.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays
// high until its result has been shown. The result appears on result for
// exactly one cycle with done high, and the receiver cannot stall it, so it
// must take it in that cycle. An enqueue, a request on an empty queue and
// the unused operation code show their result in the cycle right after
// the transfer. A purge walks the entries from the oldest until it finds
// its id, a dequeue walks all of them, and either then moves the entries
// above a removed one down. The block is ready again in the cycle after
// the result. The single read port of the entry RAM feeds one entry per
// cycle to the shared compare unit during the walk and one entry per
// cycle to the move-down pass after it.
// The entry RAM needs no clearing after reset, since only entries below the
// count are read. count_after shows the low five bits of the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_priority_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire mprq_pkg::mprq_cmd_t    cmd,
  output logic                        done,
  output mprq_pkg::mprq_result_t      result
);

  // Address width of the entry RAM and width of the entry count, which
  // must be able to hold QUEUE_DEPTH itself.
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  mprq_pkg::mprq_state_t state, state_next;

  // Control registers.
  logic [CW-1:0] count;

  // Command and walk registers.
  logic [1:0]            op;
  logic [7:0]            pid;
  logic [CW-1:0]         ridx;     // index of the entry now on the read data
  logic [CW-1:0]         pos;      // position of the best entry so far
  mprq_pkg::mprq_entry_t best;
  logic [CW-1:0]         sp;       // move-down write pointer

  // Result registers.
  logic [1:0] res_status;
  logic [7:0] res_id;
  logic [7:0] res_prio;

  // RAM ports.
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [mprq_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [mprq_pkg::ENTRY_W-1:0]   ram_rdata;
  mprq_pkg::mprq_entry_t          rd_entry;

  mprq_pkg::mprq_cmp_in_t cmp_in;
  logic                   hit;

  // Walk and removal decisions.
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   is_purge;
  logic [CW-1:0]          ridx_inc;
  logic                   scan_last;
  logic                   removing;
  logic [CW-1:0]          rm_pos;
  logic [CW-1:0]          rm_inc;
  logic                   rm_shift;
  mprq_pkg::mprq_entry_t  rm_entry;
  logic [CW-1:0]          sp_inc;
  logic [CW-1:0]          sp_inc2;
  logic                   shift_last;

  mprq_ram #(
    .WIDTH (mprq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = mprq_pkg::mprq_entry_t'(ram_rdata);

  // The compare unit looks for a new minimum during a dequeue walk and for
  // a matching id during a purge walk.
  assign is_purge        = (op == mprq_pkg::OP_PURGE);
  assign cmp_in.min_mode = !is_purge;
  assign cmp_in.first    = (ridx == '0);
  assign cmp_in.cand     = rd_entry;
  assign cmp_in.best     = best;
  assign cmp_in.key      = pid;

  mprq_cmp u_cmp (
    .cmp_in (cmp_in),
    .hit    (hit)
  );

  assign accept    = start && !busy;
  assign full      = (count >= DEPTH_C);
  assign empty     = (count == '0);
  assign ridx_inc  = ridx + ONE_C;
  assign scan_last = (ridx_inc == count);

  // A purge removes at its first match; a dequeue removes once the whole
  // queue has been seen, taking the current entry if it is a new minimum.
  assign removing = is_purge ? hit : scan_last;
  assign rm_pos   = (is_purge || hit) ? ridx : pos;
  assign rm_entry = hit ? rd_entry : best;
  assign rm_inc   = rm_pos + ONE_C;
  assign rm_shift = (rm_inc < count);

  assign sp_inc     = sp + ONE_C;
  assign sp_inc2    = sp + TWO_C;
  assign shift_last = (sp_inc2 >= count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mprq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mprq_pkg::S_IDLE: begin
        if (accept) begin
          if ((cmd.operation == mprq_pkg::OP_DEQUEUE ||
               cmd.operation == mprq_pkg::OP_PURGE) && !empty) begin
            state_next = mprq_pkg::S_SCAN;
          end else begin
            state_next = mprq_pkg::S_DONE;
          end
        end
      end
      mprq_pkg::S_SCAN: begin
        if (removing) begin
          state_next = rm_shift ? mprq_pkg::S_SHIFT : mprq_pkg::S_DONE;
        end else if (scan_last) begin
          state_next = mprq_pkg::S_DONE;
        end
      end
      mprq_pkg::S_SHIFT: begin
        if (shift_last) begin
          state_next = mprq_pkg::S_DONE;
        end
      end
      mprq_pkg::S_DONE: begin
        state_next = mprq_pkg::S_IDLE;
      end
      default: begin
        state_next = mprq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and RAM controls.
  always_comb begin
    busy      = (state != mprq_pkg::S_IDLE);
    done      = (state == mprq_pkg::S_DONE);
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = {cmd.process_id, cmd.priority_req};
    ram_raddr = '0;
    case (state)
      mprq_pkg::S_IDLE: begin
        // An enqueue is written straight into the slot past the last entry;
        // entry zero is read ahead for a walk that may follow.
        ram_we = accept && (cmd.operation == mprq_pkg::OP_ENQUEUE) && !full;
      end
      mprq_pkg::S_SCAN: begin
        // On removal, read the entry just above the removed one so the
        // move-down pass has it on the next cycle.
        ram_raddr = removing ? rm_inc[AW-1:0] : ridx_inc[AW-1:0];
      end
      mprq_pkg::S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = sp[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = sp_inc2[AW-1:0];
      end
      mprq_pkg::S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign result.status       = res_status;
  assign result.out_id       = res_id;
  assign result.out_priority = res_prio;
  assign result.count_after  = 5'(count);
  assign result.is_empty     = empty;

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        mprq_pkg::S_IDLE: begin
          if (accept && (cmd.operation == mprq_pkg::OP_ENQUEUE) && !full) begin
            count <= count + ONE_C;
          end
        end
        mprq_pkg::S_SCAN: begin
          if (removing && !rm_shift) begin
            count <= count - ONE_C;
          end
        end
        mprq_pkg::S_SHIFT: begin
          if (shift_last) begin
            count <= count - ONE_C;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Walk and result datapath.
  always_ff @(posedge clk) begin
    case (state)
      mprq_pkg::S_IDLE: begin
        if (accept) begin
          op       <= cmd.operation;
          pid      <= cmd.process_id;
          ridx     <= '0;
          pos      <= '0;
          res_id   <= '0;
          res_prio <= '0;
          case (cmd.operation)
            mprq_pkg::OP_ENQUEUE: begin
              res_status <= full ? mprq_pkg::ST_FULL : mprq_pkg::ST_OK;
            end
            mprq_pkg::OP_DEQUEUE: begin
              res_status <= empty ? mprq_pkg::ST_EMPTY : mprq_pkg::ST_OK;
            end
            mprq_pkg::OP_PURGE: begin
              // Stays at not found unless the walk finds the id.
              res_status <= mprq_pkg::ST_NOT_FOUND;
            end
            default: begin
              res_status <= mprq_pkg::ST_OK;
            end
          endcase
        end
      end
      mprq_pkg::S_SCAN: begin
        ridx <= ridx_inc;
        if (hit) begin
          pos  <= ridx;
          best <= rd_entry;
        end
        if (removing) begin
          sp         <= rm_pos;
          res_status <= mprq_pkg::ST_OK;
          res_id     <= rm_entry.id;
          res_prio   <= rm_entry.prio;
        end
      end
      mprq_pkg::S_SHIFT: begin
        sp <= sp_inc;
      end
      default: begin
        sp <= sp;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/mprq_ram.sv]
// ----------------------------------------------------------------------------
// mprq_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mprq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/mprq_cmp.sv]
// ----------------------------------------------------------------------------
// mprq_cmp: shared compare unit of the queue walk
// In minimum mode it flags a candidate whose priority is strictly lower
// than the best so far (or the first candidate); otherwise it flags a
// candidate whose id equals the key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mprq_cmp (
  input  wire mprq_pkg::mprq_cmp_in_t cmp_in,
  output logic                        hit
);

  always_comb begin
    if (cmp_in.min_mode) begin
      hit = cmp_in.first || (cmp_in.cand.prio < cmp_in.best.prio);
    end else begin
      hit = (cmp_in.cand.id == cmp_in.key);
    end
  end

endmodule

`default_nettype wire

[sv/mprq_checker.sv]
// ----------------------------------------------------------------------------
// mprq_checker: port-level checks of the min-priority ready queue
// Watches the command and result ports over time and is bound to the top
// level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mprq_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   done,
  input wire mprq_pkg::mprq_result_t result
);

  // A transfer makes the block busy on the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command transfer");

  // A result is shown only while the command is still in flight.
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without a command in flight");

  // Each result stands for one cycle and is followed by a ready cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  // No entry is reported on any error status.
  a_error_no_entry: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != mprq_pkg::ST_OK) |->
      (result.out_id == 8'd0 && result.out_priority == 8'd0))
    else $error("entry reported on an error status");

  // An empty report comes only from an empty queue.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == mprq_pkg::ST_EMPTY) |-> result.is_empty)
    else $error("empty status while entries are held");

endmodule

bind min_priority_ready_queue mprq_checker u_mprq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
